// ===== hdl/hta_pkg.sv =====
// Package for the handle table allocator: operation kinds, result status codes,
// result source selects and the controller/datapath command and status structs.
// No dependencies.
package hta_pkg;

  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  // Most results one drain item may emit.
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DRAIN   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // Source of the result loaded into the output register
  localparam logic [1:0] RES_ALLOC = 2'd0;
  localparam logic [1:0] RES_MISS  = 2'd1;
  localparam logic [1:0] RES_EMPTY = 2'd2;
  localparam logic [1:0] RES_RAM   = 2'd3;

  typedef struct packed {
    logic       cap;   // latch the input item
    logic       rd;    // read the slot RAM and latch the slot index
    logic       wr;    // store the value in the lowest free slot
    logic       clr;   // free the latched slot
    logic       load;  // load the output register
    logic [1:0] src;   // result source
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              alloc_ok;    // nonzero value and a free slot
    logic              hit;         // handle in range and slot occupied
    logic              occ_empty;
    logic              drain_last;  // current drain result is the final one
    logic              out_free;
  } sts_t;

endpackage

// ===== hdl/handle_table_allocator.sv =====
// Top level of the handle table allocator: joins the controller and datapath
// and maps the stream ports. Depends on hta_pkg, hta_ctrl and hta_datapath.
//
//  channel   dir   tdata (low bit up)                 tuser    tlast
//  s_axis    in    value[63:0], handle[79:64]         kind     -
//  m_axis    out   slot_index[15:0], slot_value[79:16] status  last
//
// Allocate loads its result straight from the execute state; release and lookup
// of an occupied slot go through one RAM read first, of a free or out-of-range
// slot not. A drain reads one occupied slot per execute/read pair of the
// controller on the single read port of the slot RAM, a result for each; an
// empty drain loads its empty result straight from the execute state.
// Reset clears the occupancy flags at once, so every slot is free.
// A stalled result holds in the output register; the next item is accepted once
// the current one has loaded its last result.
module handle_table_allocator
  import hta_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // value[63:0], handle[79:64]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // slot_index[15:0], slot_value[79:16]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast
);

  cmd_t                cmd;
  sts_t                sts;
  logic [HANDLE_W-1:0] out_index;
  logic [VALUE_W-1:0]  out_value;

  hta_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  hta_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (s_axis_tuser),
    .value_i     (s_axis_tdata[63:0]),
    .handle_i    (s_axis_tdata[79:64]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_index_o (out_index),
    .out_value_o (out_value),
    .out_status_o(m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_value, out_index};

endmodule

// ===== hdl/hta_ram.sv =====
// Generic single write, single read port RAM with a registered read.
// No dependencies.
module hta_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hta_ctrl.sv =====
// Controller of the handle table allocator: sequences accept, execute, slot read
// and result load for each item. Depends on hta_pkg.
module hta_ctrl
  import hta_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.cap = s_valid_i;
        if (s_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.kind)
          KIND_ALLOC: begin
            if (sts_i.out_free) begin
              cmd_o.load = 1'b1;
              cmd_o.src  = RES_ALLOC;
              cmd_o.wr   = sts_i.alloc_ok;
              state_d    = S_IDLE;
            end
          end
          KIND_DRAIN: begin
            if (!sts_i.occ_empty) begin
              cmd_o.rd = 1'b1;
              state_d  = S_READ;
            end else if (sts_i.out_free) begin
              cmd_o.load = 1'b1;
              cmd_o.src  = RES_EMPTY;
              state_d    = S_IDLE;
            end
          end
          default: begin
            // release and lookup
            if (sts_i.hit) begin
              cmd_o.rd = 1'b1;
              state_d  = S_READ;
            end else if (sts_i.out_free) begin
              cmd_o.load = 1'b1;
              cmd_o.src  = RES_MISS;
              state_d    = S_IDLE;
            end
          end
        endcase
      end
      S_READ: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.src  = RES_RAM;
          cmd_o.clr  = (sts_i.kind != KIND_LOOKUP);
          if (sts_i.kind == KIND_DRAIN && !sts_i.drain_last) begin
            state_d = S_EXEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);

endmodule

// ===== hdl/hta_datapath.sv =====
// Datapath of the handle table allocator: input registers, occupancy flags,
// slot RAM, priority encoders, drain counter and output register.
// Depends on hta_pkg and hta_ram.
module hta_datapath
  import hta_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [HANDLE_W-1:0] out_index_o,
  output logic [VALUE_W-1:0]  out_value_o,
  output logic [STATUS_W-1:0] out_status_o,
  output logic                out_last_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [KIND_W-1:0]   kind_q;
  logic [VALUE_W-1:0]  value_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [DEPTH-1:0]    occ_q, occ_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    cnt_q;
  logic [VALUE_W-1:0]  rdata;

  logic                out_valid_q;
  logic [HANDLE_W-1:0] out_index_q;
  logic [VALUE_W-1:0]  out_value_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_last_q;

  // Lowest set bit of a flag vector
  function automatic logic [IDX_W-1:0] first_set(input logic [DEPTH-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  logic [IDX_W-1:0] free_idx, occ_idx;
  logic             in_range, full, zero_val, out_free;
  logic [DEPTH-1:0] occ_rest;

  assign free_idx = first_set(~occ_q);
  assign occ_idx  = first_set(occ_q);
  assign full     = &occ_q;
  assign zero_val = (value_q == '0);
  assign in_range = (handle_q < HANDLE_W'(DEPTH));
  assign out_free = !out_valid_q || out_ready_i;
  assign occ_rest = occ_q & ~(DEPTH'(1) << idx_q);

  assign sts_o.kind       = kind_q;
  assign sts_o.alloc_ok   = !zero_val && !full;
  assign sts_o.hit        = in_range && occ_q[handle_q[IDX_W-1:0]];
  assign sts_o.occ_empty  = (occ_q == '0);
  assign sts_o.drain_last = (occ_rest == '0) || (cnt_q == CNT_W'(MAX_RESULTS - 1));
  assign sts_o.out_free   = out_free;

  assign idx_d = (kind_q == KIND_DRAIN) ? occ_idx : handle_q[IDX_W-1:0];

  always_comb begin
    occ_d = occ_q;
    if (cmd_i.wr) begin
      occ_d[free_idx] = 1'b1;
    end
    if (cmd_i.clr) begin
      occ_d[idx_q] = 1'b0;
    end
  end

  hta_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr),
    .waddr_i(free_idx),
    .wdata_i(value_q),
    .re_i   (cmd_i.rd),
    .raddr_i(idx_d),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q   <= kind_i;
      value_q  <= value_i;
      handle_q <= handle_i;
    end
    if (cmd_i.rd) begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      cnt_q <= '0;
    end else begin
      occ_q <= occ_d;
      if (cmd_i.cap) begin
        cnt_q <= '0;
      end else if (cmd_i.clr) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      case (cmd_i.src)
        RES_ALLOC: begin
          out_index_q  <= sts_o.alloc_ok ? HANDLE_W'(free_idx) : '0;
          out_value_q  <= sts_o.alloc_ok ? value_q : '0;
          out_status_q <= zero_val ? ST_ZERO : (full ? ST_FULL : ST_OK);
          out_last_q   <= 1'b1;
        end
        RES_MISS: begin
          out_index_q  <= handle_q;
          out_value_q  <= '0;
          out_status_q <= ST_OK;
          out_last_q   <= 1'b1;
        end
        RES_EMPTY: begin
          out_index_q  <= '0;
          out_value_q  <= '0;
          out_status_q <= ST_EMPTY;
          out_last_q   <= 1'b1;
        end
        default: begin
          out_index_q  <= HANDLE_W'(idx_q);
          out_value_q  <= rdata;
          out_status_q <= ST_OK;
          out_last_q   <= (kind_q != KIND_DRAIN) || sts_o.drain_last;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== hdl/hta_checker.sv =====
// Port-level checks for the handle table allocator, bound to the top level.
// Depends on hta_pkg and handle_table_allocator.
module hta_checker
  import hta_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // One item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous item still in progress");

  // Error and empty results carry zero data and close the item
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0) && m_axis_tlast)
    else $error("non-ok result with data or without last");

  // An ok result with a nonzero value has a slot index below 64
  a_ok_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_OK) && (m_axis_tdata[79:16] != '0)
      |-> (m_axis_tdata[15:0] < 16'd64))
    else $error("occupied slot reported beyond table range");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind handle_table_allocator hta_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// ===== tb/sv/handle_table_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for handle_table_allocator: a directed table, then random
// allocate/release/lookup/drain traffic with random stalls on both stream sides (none in the steady-flow phase).
// Depends on hta_pkg and the handle_table_allocator RTL.
module handle_table_allocator_test;
  import hta_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned PHASE_ITEMS = 120;
  localparam int unsigned IDLE_LIMIT  = 1000;

  typedef struct packed {
    logic [HANDLE_W-1:0] slot_index;
    logic [VALUE_W-1:0]  slot_value;
    logic [STATUS_W-1:0] status;
    logic                last;
  } slot_result_t;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;
    logic [HANDLE_W-1:0] handle;
    int unsigned         reps;
    bit                  typed;
    slot_result_t        want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [79:0]         s_axis_tdata = '0;  // value[63:0], handle[79:64]
  logic [1:0]          s_axis_tuser = '0;  // kind[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [79:0]         m_axis_tdata;       // slot_index[15:0], slot_value[79:16]
  logic [1:0]          m_axis_tuser;       // status[1:0]
  logic                m_axis_tlast;

  logic [VALUE_W-1:0]  slot_mirror [DEPTH];
  slot_result_t        pending_results[$];
  int unsigned         error_count = 0;
  int unsigned         idle_cycles = 0;
  bit                  steady_flow = 1'b0;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP  = 64'h8000_0000_0000_0000;

  stim_row_t directed_rows [18] = '{
    '{KIND_DRAIN,   64'd0, 16'd0,      1, 1'b1, '{16'd0, 64'd0, ST_EMPTY, 1'b1}},
    '{KIND_LOOKUP,  64'd0, 16'd0,      1, 1'b1, '{16'd0, 64'd0, ST_OK, 1'b1}},
    '{KIND_ALLOC,   64'd0, 16'd0,      1, 1'b1, '{16'd0, 64'd0, ST_ZERO, 1'b1}},
    '{KIND_ALLOC,   ONES,  16'd0,      1, 1'b1, '{16'd0, ONES, ST_OK, 1'b1}},
    '{KIND_ALLOC,   64'd1, 16'hFFFF,   1, 1'b1, '{16'd1, 64'd1, ST_OK, 1'b1}},
    '{KIND_LOOKUP,  64'd0, 16'hFFFF,   1, 1'b1, '{16'hFFFF, 64'd0, ST_OK, 1'b1}},
    '{KIND_RELEASE, 64'd0, 16'd16,     1, 1'b1, '{16'd16, 64'd0, ST_OK, 1'b1}},
    '{KIND_LOOKUP,  64'd0, 16'd0,      1, 1'b1, '{16'd0, ONES, ST_OK, 1'b1}},
    '{KIND_RELEASE, 64'd0, 16'd0,      1, 1'b1, '{16'd0, ONES, ST_OK, 1'b1}},
    '{KIND_RELEASE, 64'd0, 16'd0,      1, 1'b1, '{16'd0, 64'd0, ST_OK, 1'b1}},
    '{KIND_ALLOC,   TOP,   16'd0,      1, 1'b1, '{16'd0, TOP, ST_OK, 1'b1}},
    // fill the remaining slots
    '{KIND_ALLOC,   64'h0123_4567_89AB_CDEF, 16'd0, 14, 1'b0, '0},
    '{KIND_ALLOC,   64'd5, 16'd0,      1, 1'b1, '{16'd0, 64'd0, ST_FULL, 1'b1}},
    '{KIND_LOOKUP,  64'd0, 16'd15,     1, 1'b0, '0},
    '{KIND_RELEASE, 64'd0, 16'd7,      1, 1'b0, '0},
    '{KIND_ALLOC,   64'hDEAD_BEEF, 16'd0, 1, 1'b0, '0},
    '{KIND_DRAIN,   64'd0, 16'd0,      1, 1'b0, '0},
    '{KIND_DRAIN,   64'd0, 16'd0,      1, 1'b1, '{16'd0, 64'd0, ST_EMPTY, 1'b1}}
  };

  int unsigned alloc_share   [4] = '{70, 25, 45, 50};
  int unsigned release_share [4] = '{10, 45, 25, 20};
  int unsigned lookup_share  [4] = '{15, 25, 25, 22};

  handle_table_allocator #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < DEPTH; i++) slot_mirror[i] = '0;
  end

  // Work out the results of one accepted item and update the slot mirror.
  task automatic predict_table_op(input logic [KIND_W-1:0] kind,
                                  input logic [VALUE_W-1:0] value,
                                  input logic [HANDLE_W-1:0] handle);
    slot_result_t res;
    slot_result_t held;
    int unsigned  emitted;
    res = '0;
    held = '0;
    emitted = 0;
    res.last = 1'b1;
    case (kind)
      KIND_ALLOC: begin
        if (value == '0) begin
          res.status = ST_ZERO;
        end else begin
          res.status = ST_FULL;
          for (int i = 0; i < DEPTH; i++) begin
            if (slot_mirror[i] == '0) begin
              slot_mirror[i] = value;
              res.status = ST_OK;
              res.slot_index = i[HANDLE_W-1:0];
              res.slot_value = value;
              break;
            end
          end
        end
        pending_results.push_back(res);
      end
      KIND_RELEASE, KIND_LOOKUP: begin
        res.status = ST_OK;
        res.slot_index = handle;
        if (handle < DEPTH) begin
          res.slot_value = slot_mirror[handle[IDX_W-1:0]];
          if (kind == KIND_RELEASE) slot_mirror[handle[IDX_W-1:0]] = '0;
        end
        pending_results.push_back(res);
      end
      default: begin
        // hold each drain result back one step so the final one gets last
        for (int i = 0; i < DEPTH; i++) begin
          if (emitted < MAX_RESULTS && slot_mirror[i] != '0) begin
            if (emitted != 0) pending_results.push_back(held);
            held = '{i[HANDLE_W-1:0], slot_mirror[i], ST_OK, 1'b0};
            slot_mirror[i] = '0;
            emitted++;
          end
        end
        if (emitted == 0) begin
          res.status = ST_EMPTY;
          pending_results.push_back(res);
        end else begin
          held.last = 1'b1;
          pending_results.push_back(held);
        end
      end
    endcase
  endtask

  // Present one item after a random gap (none in steady flow); called and returns at a falling edge.
  task automatic drive_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                          input logic [HANDLE_W-1:0] handle, input bit typed,
                          input slot_result_t want);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {handle, value};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_table_op(kind, value, handle);
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
    @(negedge clk_i);
  endtask

  task automatic hold_until_settled();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned  pick;
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;
    logic [HANDLE_W-1:0] handle;
    slot_result_t none;
    none = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      for (int n = 0; n < directed_rows[r].reps; n++) begin
        drive_op(directed_rows[r].kind, directed_rows[r].value + n, directed_rows[r].handle,
                 directed_rows[r].typed, directed_rows[r].want);
      end
    end
    hold_until_settled();

    for (int phase = 0; phase < 4; phase++) begin
      steady_flow = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < alloc_share[phase]) begin
          kind = KIND_ALLOC;
        end else if (pick < alloc_share[phase] + release_share[phase]) begin
          kind = KIND_RELEASE;
        end else if (pick < alloc_share[phase] + release_share[phase]
                            + lookup_share[phase]) begin
          kind = KIND_LOOKUP;
        end else begin
          kind = KIND_DRAIN;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) value = '0;
        else if (pick < 13) value = '1;
        else value = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 85) handle = HANDLE_W'($urandom_range(0, DEPTH - 1));
        else if (pick < 93) handle = HANDLE_W'($urandom_range(DEPTH, 65535));
        else handle = HANDLE_W'($urandom);
        drive_op(kind, value, handle, 1'b0, none);
      end
      hold_until_settled();
    end

    steady_flow = 1'b0;
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("handle_table_allocator_test: clean");
    end else begin
      $display("handle_table_allocator_test: errors");
    end
    $finish;
  end

  // Result side: random stall before each result (none in steady flow), compare against the oldest expectation.
  initial begin : result_sink
    int unsigned  stall;
    slot_result_t seen;
    slot_result_t want;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = steady_flow ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      seen = '{m_axis_tdata[15:0], m_axis_tdata[79:16], m_axis_tuser, m_axis_tlast};
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result idx %h value %h status %0d last %0d", $time,
                 seen.slot_index, seen.slot_value, seen.status, seen.last);
      end else begin
        want = pending_results.pop_front();
        if (seen != want) begin
          error_count++;
          $display("%0t: expected %h/%h/%0d/%0d, got %h/%h/%0d/%0d (idx/value/status/last)",
                   $time, want.slot_index, want.slot_value, want.status, want.last,
                   seen.slot_index, seen.slot_value, seen.status, seen.last);
        end
      end
    end
  end

  // Stop a hung run: count cycles in which neither side accepts an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 IDLE_LIMIT, pending_results.size());
        $display("handle_table_allocator_test: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
